// ----- rtl/mse_pkg.sv -----
// Shared types and constants for the mean squared error loss and gradient unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

    localparam int DATA_WIDTH_DEF   = 16;
    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int COUNT_W          = 13;
    localparam int SUM_W            = 48;
    localparam int LOSS_W           = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int DIV_CNT_W        = $clog2(SUM_W + 1);

    localparam logic [LOSS_W-1:0] LOSS_MAX = 32'd4294836225;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_GRAD,
        BK_LOSS,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/mse_front.sv -----
// Front end: accepts element pairs, forms |target - prediction| and its square,
// accumulates the squares with saturation and pushes one entry per item. Uses mse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mse_front
    import mse_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ENTRY_W    = 2 + DATA_WIDTH + SUM_W
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_target_value,
    input  wire logic signed [DATA_WIDTH-1:0] s_predicted_value,
    input  wire logic                         s_last_element,
    input  wire queue_status_t                q_status,
    output logic                              q_push,
    output logic [ENTRY_W-1:0]                q_entry
);

    localparam int DW    = DATA_WIDTH;
    localparam int SQ_W  = 2 * DW;
    localparam int ACC_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
    localparam logic [ACC_W-1:0] SUM_MAX_W = ACC_W'({SUM_W{1'b1}});

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_sign_reg;
    logic                 s1_last_reg;
    logic [DW-1:0]        s1_mag_reg;
    logic                 s2_valid_reg, s2_valid_next;
    logic                 s2_sign_reg;
    logic                 s2_last_reg;
    logic [DW-1:0]        s2_mag_reg;
    logic [SQ_W-1:0]      s2_sq_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    logic signed [DW:0]   diff;
    logic [DW:0]          diff_abs;
    logic                 s1_en;
    logic                 s2_en;
    logic [ACC_W-1:0]     acc_total;
    logic [SUM_W-1:0]     acc_sat;

    assign diff     = {s_target_value[DW-1], s_target_value}
                    - {s_predicted_value[DW-1], s_predicted_value};
    assign diff_abs = diff[DW] ? (DW+1)'(-diff) : diff;

    assign q_push  = s2_valid_reg && !q_status.full;
    assign s2_en   = !s2_valid_reg || q_push;
    assign s1_en   = !s1_valid_reg || s2_en;
    // hold ready low while in reset
    assign s_ready = s1_en && aresetn;

    assign s1_valid_next = s1_en ? s_valid : s1_valid_reg;
    assign s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;

    // saturating accumulate of the square leaving stage two
    assign acc_total = ACC_W'(sum_reg) + ACC_W'(s2_sq_reg);
    assign acc_sat   = (acc_total > SUM_MAX_W) ? {SUM_W{1'b1}} : acc_total[SUM_W-1:0];

    always_comb begin
        sum_next = sum_reg;
        if (q_push) begin
            sum_next = s2_last_reg ? '0 : acc_sat;
        end
    end

    assign q_entry = {s2_sign_reg, s2_last_reg, s2_mag_reg, acc_sat};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_sign_reg <= diff[DW];
            s1_last_reg <= s_last_element;
            s1_mag_reg  <= diff_abs[DW-1:0];
        end
        if (s2_en) begin
            s2_sign_reg <= s1_sign_reg;
            s2_last_reg <= s1_last_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_sq_reg   <= SQ_W'(s1_mag_reg) * SQ_W'(s1_mag_reg);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mse_queue.sv -----
// Small register queue between the front end and the divider back end.
// Uses mse_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module mse_queue
    import mse_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output queue_status_t         status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!status.full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("queue pop while empty");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ----- rtl/mse_back.sv -----
// Back end: pops queue entries and runs a shared restoring divider, one quotient
// bit per cycle, for the gradient and, on the last element, the loss. Uses mse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mse_back
    import mse_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ENTRY_W    = 2 + DATA_WIDTH + SUM_W
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [COUNT_W-1:0]           divisor,
    input  wire queue_status_t                q_status,
    input  wire logic [ENTRY_W-1:0]           q_entry,
    output logic                              q_pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH+1:0]      m_gradient,
    output logic [LOSS_W-1:0]                 m_loss,
    output logic                              m_loss_valid
);

    localparam int DW   = DATA_WIDTH;
    localparam int GD_W = DW + 2;

    back_state_t            state_reg, state_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]       dvd_reg, dvd_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   sign_reg, sign_next;
    logic                   last_reg, last_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [GD_W-1:0] grad_reg, grad_next;
    logic [LOSS_W-1:0]      loss_reg, loss_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [GD_W-1:0] m_gradient_reg, m_gradient_next;
    logic [LOSS_W-1:0]      m_loss_reg, m_loss_next;
    logic                   m_loss_valid_reg, m_loss_valid_next;

    logic                   e_sign;
    logic                   e_last;
    logic [DW-1:0]          e_mag;
    logic [SUM_W-1:0]       e_sum;
    logic [COUNT_W:0]       trial;
    logic [COUNT_W+1:0]     trial_diff;
    logic                   trial_ge;
    logic [COUNT_W-1:0]     rem_step;
    logic [SUM_W-1:0]       dvd_step;
    logic [GD_W-1:0]        grad_q;

    assign {e_sign, e_last, e_mag, e_sum} = q_entry;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial      = {rem_reg, dvd_reg[SUM_W-1]};
    assign trial_diff = {1'b0, trial} - {2'b00, divisor};
    assign trial_ge   = !trial_diff[COUNT_W+1];
    assign rem_step   = trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
    assign dvd_step   = {dvd_reg[SUM_W-2:0], trial_ge};
    assign grad_q     = {1'b0, dvd_step[DW:0]};

    always_comb begin
        state_next        = state_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        cnt_next          = cnt_reg;
        sign_next         = sign_reg;
        last_next         = last_reg;
        sum_next          = sum_reg;
        grad_next         = grad_reg;
        loss_next         = loss_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_gradient_next   = m_gradient_reg;
        m_loss_next       = m_loss_reg;
        m_loss_valid_next = m_loss_valid_reg;
        q_pop             = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    sign_next  = e_sign;
                    last_next  = e_last;
                    sum_next   = e_sum;
                    rem_next   = '0;
                    dvd_next   = {e_mag, 1'b0, (SUM_W - DW - 1)'(0)};
                    cnt_next   = DIV_CNT_W'(DW + 1);
                    state_next = BK_GRAD;
                end
            end
            BK_GRAD: begin
                rem_next = rem_step;
                dvd_next = dvd_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    grad_next = sign_reg ? -grad_q : grad_q;
                    loss_next = '0;
                    if (last_reg) begin
                        rem_next   = '0;
                        dvd_next   = sum_reg;
                        cnt_next   = DIV_CNT_W'(SUM_W);
                        state_next = BK_LOSS;
                    end else begin
                        state_next = BK_DONE;
                    end
                end
            end
            BK_LOSS: begin
                rem_next = rem_step;
                dvd_next = dvd_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    loss_next  = (dvd_step > SUM_W'(LOSS_MAX)) ? LOSS_MAX
                                                               : dvd_step[LOSS_W-1:0];
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                // hold the result until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_gradient_next   = grad_reg;
                    m_loss_next       = loss_reg;
                    m_loss_valid_next = last_reg;
                    state_next        = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg          <= rem_next;
        dvd_reg          <= dvd_next;
        cnt_reg          <= cnt_next;
        sign_reg         <= sign_next;
        last_reg         <= last_next;
        sum_reg          <= sum_next;
        grad_reg         <= grad_next;
        loss_reg         <= loss_next;
        m_gradient_reg   <= m_gradient_next;
        m_loss_reg       <= m_loss_next;
        m_loss_valid_reg <= m_loss_valid_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_gradient   = m_gradient_reg;
    assign m_loss       = m_loss_reg;
    assign m_loss_valid = m_loss_valid_reg;

    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DONE && m_valid_reg && !m_ready) |=> (state_reg == BK_DONE))
        else $error("result dropped while output stalled");

    a_loss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_loss_valid_reg) |-> (m_loss_reg == '0))
        else $error("loss nonzero on non-last result");

    a_loss_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_LOSS) |-> last_reg)
        else $error("loss division on non-last element");

    a_grad_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_GRAD && cnt_reg == DIV_CNT_W'(1) && !last_reg)
        |=> (state_reg == BK_DONE))
        else $error("gradient division did not finish");

endmodule

`default_nettype wire

// ----- rtl/mse_loss_and_gradient_unit.sv -----
// Mean squared error loss and gradient unit: top level.
// Element pairs enter on the s_ channel (valid/ready); each is accepted when
// s_valid and s_ready are both high and yields exactly one result on the m_
// channel: gradient = 2*(target - prediction)/N in Q6.12, truncated toward zero.
// On an element with s_last_element set the result also carries the run's mean
// squared error in Q8.24 (saturated at 65535^2) with m_loss_valid high; m_loss is
// zero otherwise. N must be written by the user through the cfg_ channel only
// while the unit is idle; the block itself does not enforce this. Zero counts
// as one and counts above MAX_ELEMENTS are clamped. Throughput: a bit-serial
// divider sets the rate, one quotient bit per cycle. An ordinary element runs
// a gradient division in the back end; a last element adds a loss division
// over the accumulated sum. Before the back end, an element passes the front
// pipeline registers s1 and s2 and the queue. A four-entry queue lets the front
// keep accepting while the divider works or the receiver stalls; when m_ready is
// low the result holds in the output register and the queue fills, after which
// s_ready drops.
// Reset (aresetn low, synchronous) clears the accumulator, empties the queue,
// drops m_valid and sets N to one; both ready outputs stay low during reset.
// Depends on mse_pkg, mse_front, mse_queue and mse_back.
`timescale 1ns / 1ps
`default_nettype none

module mse_loss_and_gradient_unit
    import mse_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [COUNT_W-1:0]           cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_target_value,
    input  wire logic signed [DATA_WIDTH-1:0] s_predicted_value,
    input  wire logic                         s_last_element,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH+1:0]      m_gradient,
    output logic [LOSS_W-1:0]                 m_loss,
    output logic                              m_loss_valid
);

    localparam int ENTRY_W = 2 + DATA_WIDTH + SUM_W;
    localparam int LIM_W   = 18;

    logic [COUNT_W-1:0] divisor_reg, divisor_next;
    queue_status_t      q_status;
    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] pop_entry;

    assign cfg_ready = aresetn;

    // store the divisor already clamped to 1..MAX_ELEMENTS
    always_comb begin
        divisor_next = divisor_reg;
        if (cfg_valid) begin
            if (cfg_data == '0) begin
                divisor_next = COUNT_W'(1);
            end else if (LIM_W'(cfg_data) > LIM_W'(MAX_ELEMENTS)) begin
                divisor_next = COUNT_W'(MAX_ELEMENTS);
            end else begin
                divisor_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= COUNT_W'(1);
        end else begin
            divisor_reg <= divisor_next;
        end
    end

    mse_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_target_value    (s_target_value),
        .s_predicted_value (s_predicted_value),
        .s_last_element    (s_last_element),
        .q_status          (q_status),
        .q_push            (q_push),
        .q_entry           (push_entry)
    );

    mse_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_entry),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .status    (q_status)
    );

    mse_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .divisor      (divisor_reg),
        .q_status     (q_status),
        .q_entry      (pop_entry),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gradient   (m_gradient),
        .m_loss       (m_loss),
        .m_loss_valid (m_loss_valid)
    );

endmodule

`default_nettype wire
